FILE: sv/gn2o_pkg.sv
// shared types and constants for the 2d gradient noise block
package gn2o_pkg;

    // fixed point format of coordinates and fades
    localparam int FRAC_BITS = 16;
    localparam logic signed [17:0] ONE_FIX = 18'sd65536;
    localparam logic signed [20:0] FADE_A_OFS = 21'sd983040;
    localparam logic signed [21:0] FADE_B_OFS = 22'sd655360;

    // gradient table geometry
    localparam int TABLE_BITS = 10;
    localparam int TABLE_DEPTH = 1 << TABLE_BITS;

    // corner hash constants, the add term is 7782501394 modulo 2^32
    localparam logic [31:0] HASH_MUL_X = 32'd1055910892;
    localparam logic [31:0] HASH_MUL_Y = 32'd1556193525;
    localparam logic [31:0] HASH_ADD = 32'd3487534098;
    localparam logic [TABLE_BITS-1:0] HASH_MUL_X_LO = HASH_MUL_X[TABLE_BITS-1:0];
    localparam logic [TABLE_BITS-1:0] HASH_MUL_Y_LO = HASH_MUL_Y[TABLE_BITS-1:0];
    localparam logic [TABLE_BITS-1:0] HASH_ADD_LO = HASH_ADD[TABLE_BITS-1:0];

    // item opcodes
    localparam logic OP_EVAL = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // configuration register indexes and reset values
    localparam logic CFG_OCTAVE_COUNT = 1'b0;
    localparam logic CFG_PERSISTENCE = 1'b1;
    localparam logic [3:0] OCTAVE_RESET = 4'd4;
    localparam logic [16:0] PERS_RESET = 17'd32768;
    localparam logic [16:0] AMP_ONE = 17'd65536;

    // output saturation limits
    localparam logic signed [15:0] NOISE_MAX = 16'sh7fff;
    localparam logic signed [15:0] NOISE_MIN = 16'sh8000;

    // gradient codes
    typedef enum logic [1:0] {
        GRAD_POS_X = 2'd0,
        GRAD_NEG_X = 2'd1,
        GRAD_POS_Y = 2'd2,
        GRAD_NEG_Y = 2'd3
    } t_grad;

    // dot product of a gradient with a corner offset
    function automatic logic signed [17:0] grad_dot(input t_grad code,
                                                    input logic signed [17:0] dx,
                                                    input logic signed [17:0] dy);
        logic signed [17:0] res;
        case (code)
            GRAD_POS_X: res = dx;
            GRAD_NEG_X: res = -dx;
            GRAD_POS_Y: res = dy;
            GRAD_NEG_Y: res = -dy;
            default:    res = dx;
        endcase
        return res;
    endfunction

endpackage

FILE: sv/gradient_noise_2d_octaves.sv
// top level of the fractal 2d gradient noise block
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_opcode, i_x_coord, i_y_coord,
//                                                 i_table_index, i_table_value
//  output    out        o_out_valid / i_out_stall o_noise_value
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// a load writes the table entry at the transfer edge
// an evaluate runs per octave four table reads through the single read port,
// then x blend, y blend, weighting and accumulation; after the last octave
// come a setup step and the bit-serial normalizing divider, then the result is presented
// reset returns control and configuration to their reset values, the gradient table is not cleared
// a result waits in the output register; a stalled output holds the next result
// in the final step while new loads and points wait on o_in_stall
module gradient_noise_2d_octaves #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_opcode,
    input  logic signed [31:0]                 i_x_coord,
    input  logic signed [31:0]                 i_y_coord,
    input  logic [gn2o_pkg::TABLE_BITS-1:0]    i_table_index,
    input  logic [1:0]                         i_table_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [15:0]                 o_noise_value,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [16:0]                        i_cfg_data
);

    localparam int OW = $clog2(MAX_OCTAVES + 1);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_RD0  = 11'b00000000010,
        ST_RD1  = 11'b00000000100,
        ST_RD2  = 11'b00000001000,
        ST_RD3  = 11'b00000010000,
        ST_LX   = 11'b00000100000,
        ST_LY   = 11'b00001000000,
        ST_ACC  = 11'b00010000000,
        ST_SUM  = 11'b00100000000,
        ST_PREP = 11'b01000000000,
        ST_DIV  = 11'b10000000000
    } t_state;

    localparam t_state ST_DONE_ALIAS = ST_DIV;

    t_state r_state, n_state;

    // configuration
    logic [3:0]  r_oct_cnt;
    logic [16:0] r_pers;

    // octave loop state
    logic [31:0]          r_x, r_y;
    logic [OW-1:0]        r_n, r_k;
    logic [16:0]          r_amp;
    logic signed [47:0]   r_sum;
    logic [20:0]          r_total;

    // corner codes
    gn2o_pkg::t_grad r_c0, r_c1, r_c2;

    // fade pipeline, lane 0 is x and lane 1 is y
    logic [15:0] w_t [2];
    logic [15:0] r_sq [2];
    logic [19:0] r_b [2];
    logic [15:0] r_t3 [2];
    logic [19:0] r_b2 [2];
    logic [16:0] r_fade [2];

    // blend registers
    logic signed [36:0] r_mt, r_mb;
    logic signed [17:0] r_d00, r_d01;
    logic signed [38:0] r_my;
    logic signed [19:0] r_top;
    logic signed [38:0] r_wp;

    // divider
    logic [46:0] r_rem;
    logic [37:0] r_dvs;
    logic [15:0] r_q;
    logic [3:0]  r_cnt;
    logic        r_neg, r_ovf, r_fin;

    // output register
    logic               r_out_valid;
    logic signed [15:0] r_out;

    logic w_in_acc;
    logic w_ram_we;
    logic [gn2o_pkg::TABLE_BITS-1:0] w_raddr;
    logic [1:0] w_rdata;

    assign w_in_acc = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_noise_value = r_out;
    assign w_ram_we = w_in_acc && (i_opcode == gn2o_pkg::OP_LOAD);

    // gradient table
    gn2o_ram #(
        .WIDTH (2),
        .DEPTH (gn2o_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_table_index),
        .i_wdata (i_table_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // corner hash, only the low table bits of each product matter
    logic [gn2o_pkg::TABLE_BITS-1:0] w_cxl, w_cyl, w_px0, w_px1, w_py0, w_py1;
    logic [gn2o_pkg::TABLE_BITS-1:0] w_hx, w_hy;

    assign w_cxl = r_x[gn2o_pkg::FRAC_BITS +: gn2o_pkg::TABLE_BITS];
    assign w_cyl = r_y[gn2o_pkg::FRAC_BITS +: gn2o_pkg::TABLE_BITS];
    assign w_px0 = w_cxl * gn2o_pkg::HASH_MUL_X_LO;
    assign w_py0 = w_cyl * gn2o_pkg::HASH_MUL_Y_LO;
    assign w_px1 = w_px0 + gn2o_pkg::HASH_MUL_X_LO;
    assign w_py1 = w_py0 + gn2o_pkg::HASH_MUL_Y_LO;

    // pick the corner for this read slot
    always_comb begin
        case (r_state)
            ST_RD1:  begin w_hx = w_px1; w_hy = w_py0; end
            ST_RD2:  begin w_hx = w_px0; w_hy = w_py1; end
            ST_RD3:  begin w_hx = w_px1; w_hy = w_py1; end
            default: begin w_hx = w_px0; w_hy = w_py0; end
        endcase
        w_raddr = (w_hx ^ w_hy) + gn2o_pkg::HASH_ADD_LO;
    end

    // quintic fade, three multiply stages per lane
    assign w_t[0] = r_x[gn2o_pkg::FRAC_BITS-1:0];
    assign w_t[1] = r_y[gn2o_pkg::FRAC_BITS-1:0];

    logic [31:0]        w_sq_full [2];
    logic signed [20:0] w_a [2];
    logic signed [37:0] w_ta [2];
    logic signed [21:0] w_bb [2];
    logic [31:0]        w_t3_full [2];
    logic [35:0]        w_fd_full [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_sq_full[l] = 32'(w_t[l]) * 32'(w_t[l]);
            w_a[l] = $signed(21'(w_t[l]) * 21'd6) - gn2o_pkg::FADE_A_OFS;
            w_ta[l] = 38'($signed({1'b0, w_t[l]})) * 38'(w_a[l]);
            w_bb[l] = 22'(w_ta[l] >>> gn2o_pkg::FRAC_BITS) + gn2o_pkg::FADE_B_OFS;
            w_t3_full[l] = 32'(r_sq[l]) * 32'(w_t[l]);
            w_fd_full[l] = 36'(r_t3[l]) * 36'(r_b2[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            r_sq[l]   <= w_sq_full[l][31:16];
            r_b[l]    <= w_bb[l][19:0];
            r_t3[l]   <= w_t3_full[l][31:16];
            r_b2[l]   <= r_b[l];
            r_fade[l] <= w_fd_full[l][32:16];
        end
    end

    // corner offsets and dot products
    logic signed [17:0] w_dx0, w_dx1, w_dy0, w_dy1;
    logic signed [17:0] w_d00, w_d10, w_d01, w_d11;
    logic signed [18:0] w_dif_t, w_dif_b;

    assign w_dx0 = $signed({2'b00, w_t[0]});
    assign w_dy0 = $signed({2'b00, w_t[1]});
    assign w_dx1 = w_dx0 - gn2o_pkg::ONE_FIX;
    assign w_dy1 = w_dy0 - gn2o_pkg::ONE_FIX;
    assign w_d00 = gn2o_pkg::grad_dot(r_c0, w_dx0, w_dy0);
    assign w_d10 = gn2o_pkg::grad_dot(r_c1, w_dx1, w_dy0);
    assign w_d01 = gn2o_pkg::grad_dot(r_c2, w_dx0, w_dy1);
    assign w_d11 = gn2o_pkg::grad_dot(gn2o_pkg::t_grad'(w_rdata), w_dx1, w_dy1);
    assign w_dif_t = 19'(w_d10) - 19'(w_d00);
    assign w_dif_b = 19'(w_d11) - 19'(w_d01);

    // y blend and octave value
    logic signed [19:0] w_top, w_bot;
    logic signed [20:0] w_dif_y, w_oct;

    assign w_top = 20'(r_d00) + 20'(r_mt >>> gn2o_pkg::FRAC_BITS);
    assign w_bot = 20'(r_d01) + 20'(r_mb >>> gn2o_pkg::FRAC_BITS);
    assign w_dif_y = 21'(w_bot) - 21'(w_top);
    assign w_oct = 21'(r_top) + 21'(r_my >>> gn2o_pkg::FRAC_BITS);

    // amplitude update
    logic [16:0] w_pers;
    logic [33:0] w_amp_full;

    assign w_pers = (r_pers > gn2o_pkg::AMP_ONE) ? gn2o_pkg::AMP_ONE : r_pers;
    assign w_amp_full = 34'(r_amp) * 34'(w_pers);

    // octave count clamp
    logic [4:0]    w_cnt5;
    logic [OW-1:0] w_n;

    always_comb begin
        w_cnt5 = {1'b0, r_oct_cnt};
        if (w_cnt5 == 5'd0) begin
            w_n = OW'(1);
        end else if (w_cnt5 > 5'(MAX_OCTAVES)) begin
            w_n = OW'(MAX_OCTAVES);
        end else begin
            w_n = OW'(w_cnt5);
        end
    end

    // divider setup values
    logic [47:0] w_abs;
    logic [21:0] w_den;

    assign w_abs = r_sum[47] ? 48'(-r_sum) : 48'(r_sum);
    assign w_den = {r_total, 1'b0};

    // saturated quotient
    logic signed [15:0] w_sat;

    always_comb begin
        if (r_ovf) begin
            w_sat = r_neg ? gn2o_pkg::NOISE_MIN : gn2o_pkg::NOISE_MAX;
        end else if (!r_neg) begin
            w_sat = (r_q > 16'd32767) ? gn2o_pkg::NOISE_MAX : $signed(r_q);
        end else begin
            w_sat = (r_q > 16'd32768) ? gn2o_pkg::NOISE_MIN : $signed(~r_q + 16'd1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_opcode == gn2o_pkg::OP_EVAL)) begin
                    n_state = ST_RD0;
                end
            end
            ST_RD0:  n_state = ST_RD1;
            ST_RD1:  n_state = ST_RD2;
            ST_RD2:  n_state = ST_RD3;
            ST_RD3:  n_state = ST_LX;
            ST_LX:   n_state = ST_LY;
            ST_LY:   n_state = ST_ACC;
            ST_ACC:  n_state = ST_SUM;
            ST_SUM:  n_state = (r_k == OW'(r_n - 1'b1)) ? ST_PREP : ST_RD0;
            ST_PREP: n_state = ST_DIV;
            ST_DIV: begin
                if (r_fin && (!r_out_valid || !i_out_stall)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_oct_cnt   <= gn2o_pkg::OCTAVE_RESET;
            r_pers      <= gn2o_pkg::PERS_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gn2o_pkg::CFG_OCTAVE_COUNT: r_oct_cnt <= i_cfg_data[3:0];
                    gn2o_pkg::CFG_PERSISTENCE:  r_pers <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_DONE_ALIAS && r_fin && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x     <= i_x_coord;
                r_y     <= i_y_coord;
                r_n     <= w_n;
                r_k     <= '0;
                r_amp   <= gn2o_pkg::AMP_ONE;
                r_sum   <= '0;
                r_total <= '0;
            end
            ST_RD1: r_c0 <= gn2o_pkg::t_grad'(w_rdata);
            ST_RD2: r_c1 <= gn2o_pkg::t_grad'(w_rdata);
            ST_RD3: r_c2 <= gn2o_pkg::t_grad'(w_rdata);
            ST_LX: begin
                r_mt  <= 37'(w_dif_t) * 37'($signed({1'b0, r_fade[0]}));
                r_mb  <= 37'(w_dif_b) * 37'($signed({1'b0, r_fade[0]}));
                r_d00 <= w_d00;
                r_d01 <= w_d01;
            end
            ST_LY: begin
                r_my  <= 39'(w_dif_y) * 39'($signed({1'b0, r_fade[1]}));
                r_top <= w_top;
            end
            ST_ACC: r_wp <= 39'(w_oct) * 39'($signed({1'b0, r_amp}));
            ST_SUM: begin
                r_sum   <= r_sum + 48'(r_wp);
                r_total <= r_total + 21'(r_amp);
                r_amp   <= w_amp_full[32:16];
                r_x     <= {r_x[30:0], 1'b0};
                r_y     <= {r_y[30:0], 1'b0};
                r_k     <= r_k + 1'b1;
            end
            ST_PREP: begin
                r_rem <= w_abs[46:0];
                r_neg <= r_sum[47];
                r_ovf <= w_abs[46:0] >= 47'({w_den, 16'b0});
                r_dvs <= {1'b0, w_den, 15'b0};
                r_q   <= '0;
                r_cnt <= '0;
                r_fin <= 1'b0;
            end
            ST_DIV: begin
                if (!r_fin) begin
                    if (r_rem >= 47'(r_dvs)) begin
                        r_rem <= r_rem - 47'(r_dvs);
                        r_q   <= {r_q[14:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[14:0], 1'b0};
                    end
                    r_dvs <= r_dvs >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    r_fin <= (r_cnt == 4'd15);
                end else if (!r_out_valid || !i_out_stall) begin
                    r_out <= w_sat;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    // a result only appears out of the final divider step
    a_out_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DIV) && $past(r_fin))
        else $error("result raised outside the divider finish");

    // restoring divider keeps the remainder below twice the divisor
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && !r_ovf) |-> ({1'b0, r_rem} < 48'({r_dvs, 1'b0})))
        else $error("divider remainder out of range");

    // the first octave always adds full amplitude to the total
    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PREP) |-> (r_total != '0))
        else $error("zero amplitude total at normalization");

    // a table load transfer never starts the octave sequencer
    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_opcode == gn2o_pkg::OP_LOAD) |=> (r_state == ST_IDLE))
        else $error("load transfer left idle");
`endif

endmodule

FILE: sv/gn2o_ram.sv
// generic single port write, single port read ram with registered read
module gn2o_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
